[design/tsg_pkg.sv]
// ----------------------------------------------------------------------------
// tsg_pkg: shared types and constants for the triangle span generator
// Sequencer states, triangle part codes, fixed-point widths and the
// request/response words between the sequencer and the shared divider.
// ----------------------------------------------------------------------------
package tsg_pkg;

  localparam int FRAC_W     = 16;              // fraction bits, Q8.16 dividend and quotient
  localparam int DIV_W      = 24;              // dividend / quotient width
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int DVS_W      = 6;               // divisor is a row difference
  localparam int ACC_W      = 26;              // signed edge accumulator
  localparam int MAX_SPANS  = 64;
  localparam int CNT_W      = 7;               // holds MAX_SPANS itself
  localparam int NUM_W      = 14;              // split-point numerator

  typedef enum logic [2:0] {
    S_IDLE,
    S_SX_GO,
    S_SX_WAIT,
    S_E1_GO,
    S_E1_WAIT,
    S_E2_GO,
    S_E2_WAIT,
    S_EMIT
  } tsg_state_t;

  // Which stretch of the triangle is being walked
  typedef enum logic [1:0] {
    P_BFLAT,   // bottom-flat: whole triangle, upward
    P_TFLAT,   // top-flat: whole triangle but its flat row, downward
    P_GBOT,    // split triangle, lower part, upward to middle row
    P_GTOP     // split triangle, upper part, downward above middle row
  } tsg_part_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } tsg_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } tsg_div_rsp_t;

endpackage

[design/tsg_div.sv]
// ----------------------------------------------------------------------------
// tsg_div: shared restoring divider
// Unsigned DIV_W by DVS_W division, one quotient bit per cycle. A zero
// divisor yields a zero quotient.
// ----------------------------------------------------------------------------
module tsg_div
  import tsg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  tsg_div_req_t req,
  output tsg_div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0]     rmd_r, rmd_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DVS_W:0]       trial;
  logic                 fits;

  assign trial = {rmd_r, quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rmd_nxt  = rmd_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_W - 1);
      rmd_nxt  = '0;
      dvs_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract where it fits
      rmd_nxt = fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rmd_r <= rmd_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = (dvs_r == '0) ? '0 : quo_r;

endmodule

[design/triangle_scanline_span_generator.sv]
// ----------------------------------------------------------------------------
// triangle_scanline_span_generator: scanline fill of one triangle
// Sorts the vertices by row, works out edge steps with a shared divider
// and emits one horizontal span per row walked, at most SPAN_CAP in all.
// ----------------------------------------------------------------------------
// Input channel (in_*): one word per triangle, three vertices and a shade.
// Output channel (out_*): one word per span, row, both edge columns and the
// shade; out_tlast marks the final span of the triangle.
// Timing: a triangle is taken only while the sequencer is idle. Every edge
// step and the split column come from one restoring divider at one quotient
// bit a cycle. A flat triangle needs two divisions, a general one five
// (split column plus two per part), then one span per cycle while the
// receiver keeps up.
// Spans pass through one output register; while it is held by a stalled
// receiver the walk waits. The last span may still be held when the next
// triangle is taken.
// Reset clears the sequencer and the output valid; nothing is kept between
// triangles.
// ----------------------------------------------------------------------------
module triangle_scanline_span_generator
  import tsg_pkg::*;
#(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 256
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // vertex_a_x[7:0], vertex_a_y[13:8], vertex_b_x[21:14], vertex_b_y[27:22],
  // vertex_c_x[35:28], vertex_c_y[41:36], shade[49:42], zero fill above
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // span_row[5:0], span_x_first[13:6], span_x_second[21:14],
  // span_shade[29:22], zero fill above
  output logic [31:0] out_tdata,
  output logic        out_tlast   // last_span
);

  localparam int             SPAN_CAP = (GRID_ROWS < MAX_SPANS) ? GRID_ROWS : MAX_SPANS;
  localparam logic [12:0]    COL_MAX  = 13'(GRID_COLS - 1);
  localparam logic [CNT_W-1:0] CAP_LAST = CNT_W'(SPAN_CAP - 1);

  // clamp an accumulator to a grid column
  function automatic logic [7:0] col_of(input logic signed [ACC_W-1:0] acc);
    logic [12:0] ipart;
    ipart = {4'b0, acc[ACC_W-2:FRAC_W]};
    if (acc[ACC_W-1])         col_of = '0;
    else if (ipart > COL_MAX) col_of = COL_MAX[7:0];
    else                      col_of = acc[FRAC_W+7:FRAC_W];
  endfunction

  tsg_state_t state_r, state_nxt;
  tsg_part_t  part_r, part_nxt;

  logic [7:0] x0_r, x1_r, x2_r, x0_nxt, x1_nxt, x2_nxt;
  logic [5:0] y0_r, y1_r, y2_r, y0_nxt, y1_nxt, y2_nxt;
  logic [7:0] shade_r, shade_nxt;
  logic [7:0] sx_r, sx_nxt;
  logic signed [ACC_W-1:0] step1_r, step2_r, step1_nxt, step2_nxt;
  logic signed [ACC_W-1:0] acc1_r, acc2_r, acc1_nxt, acc2_nxt;
  logic [5:0]       row_r, row_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [CNT_W-1:0] spans_r, spans_nxt;

  logic        out_tvalid_r, out_tvalid_nxt;
  logic [5:0]  out_row_r, out_row_nxt;
  logic [7:0]  out_x1_r, out_x1_nxt, out_x2_r, out_x2_nxt;
  logic [7:0]  out_shade_r, out_shade_nxt;
  logic        out_last_r, out_last_nxt;

  // input fields
  logic [7:0] a_x, b_x, c_x, in_shade;
  logic [5:0] a_y, b_y, c_y;
  assign a_x      = in_tdata[7:0];
  assign a_y      = in_tdata[13:8];
  assign b_x      = in_tdata[21:14];
  assign b_y      = in_tdata[27:22];
  assign c_x      = in_tdata[35:28];
  assign c_y      = in_tdata[41:36];
  assign in_shade = in_tdata[49:42];

  // vertex ordering by row with the fixed tie rules
  logic [7:0] sv0_x, sv1_x, sv2_x;
  logic [5:0] sv0_y, sv1_y, sv2_y;
  always_comb begin
    if (a_y <= b_y && a_y <= c_y) begin
      sv0_x = a_x; sv0_y = a_y;
      if (b_y < c_y) begin
        sv1_x = b_x; sv1_y = b_y; sv2_x = c_x; sv2_y = c_y;
      end else begin
        sv1_x = c_x; sv1_y = c_y; sv2_x = b_x; sv2_y = b_y;
      end
    end else if (b_y <= a_y && b_y <= c_y) begin
      sv0_x = b_x; sv0_y = b_y;
      if (c_y < a_y) begin
        sv1_x = c_x; sv1_y = c_y; sv2_x = a_x; sv2_y = a_y;
      end else begin
        sv1_x = a_x; sv1_y = a_y; sv2_x = c_x; sv2_y = c_y;
      end
    end else begin
      sv0_x = c_x; sv0_y = c_y;
      if (a_y < b_y) begin
        sv1_x = a_x; sv1_y = a_y; sv2_x = b_x; sv2_y = b_y;
      end else begin
        sv1_x = b_x; sv1_y = b_y; sv2_x = a_x; sv2_y = a_y;
      end
    end
  end

  // row differences of the sorted vertices
  logic [5:0] dy01, dy02, dy12;
  assign dy01 = y1_r - y0_r;
  assign dy02 = y2_r - y0_r;
  assign dy12 = y2_r - y1_r;

  // split column numerator: x0*dy12 + x2*dy01
  logic [NUM_W-1:0] prod_a, prod_b, num;
  assign prod_a = NUM_W'(x0_r) * NUM_W'(dy12);
  assign prod_b = NUM_W'(x2_r) * NUM_W'(dy01);
  assign num    = prod_a + prod_b;

  // walk setup for the current part
  logic       part_up;
  logic       part_final;
  logic [5:0] part_row, part_dy;
  logic [7:0] part_xs, part_xe1, part_xe2;
  logic [CNT_W-1:0] part_cnt;

  always_comb begin
    case (part_r)
      P_BFLAT: begin
        part_up = 1'b1; part_row = y0_r; part_xs = x0_r;
        part_xe1 = x1_r; part_xe2 = x2_r; part_dy = dy01;
      end
      P_TFLAT: begin
        part_up = 1'b0; part_row = y2_r; part_xs = x2_r;
        part_xe1 = x0_r; part_xe2 = x1_r; part_dy = dy02;
      end
      P_GBOT: begin
        part_up = 1'b1; part_row = y0_r; part_xs = x0_r;
        part_xe1 = x1_r; part_xe2 = sx_r; part_dy = dy01;
      end
      P_GTOP: begin
        part_up = 1'b0; part_row = y2_r; part_xs = x2_r;
        part_xe1 = x1_r; part_xe2 = sx_r; part_dy = dy12;
      end
      default: begin
        part_up = 1'b1; part_row = y0_r; part_xs = x0_r;
        part_xe1 = x1_r; part_xe2 = x2_r; part_dy = dy01;
      end
    endcase
    // upward walks include the far row, downward ones stop short of it
    part_cnt   = part_up ? CNT_W'(part_dy) + 1'b1 : CNT_W'(part_dy);
    part_final = (part_r != P_GBOT);
  end

  // signed column change of each edge, split into sign and magnitude
  logic [8:0] d1, d2;
  logic       neg1, neg2;
  logic [7:0] mag1, mag2;
  assign d1   = {1'b0, part_xe1} - {1'b0, part_xs};
  assign d2   = {1'b0, part_xe2} - {1'b0, part_xs};
  assign neg1 = d1[8];
  assign neg2 = d2[8];
  assign mag1 = neg1 ? 8'(-d1) : d1[7:0];
  assign mag2 = neg2 ? 8'(-d2) : d2[7:0];

  tsg_div_req_t div_req;
  tsg_div_rsp_t div_rsp;

  tsg_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {mag1, FRAC_W'(0)};
    div_req.divisor  = part_dy;
    case (state_r)
      S_SX_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(num);
        div_req.divisor  = dy02;
      end
      S_E1_GO: begin
        div_req.start    = 1'b1;
      end
      S_E2_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {mag2, FRAC_W'(0)};
      end
      default: begin
        div_req.start    = 1'b0;
      end
    endcase
  end

  logic signed [ACC_W-1:0] quo_s;
  assign quo_s = $signed({2'b0, div_rsp.quotient});

  logic out_free;
  logic span_last;
  assign out_free  = !out_tvalid_r || out_tready;
  assign span_last = (part_final && left_r == CNT_W'(1)) || (spans_r == CAP_LAST);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    part_nxt       = part_r;
    x0_nxt = x0_r; x1_nxt = x1_r; x2_nxt = x2_r;
    y0_nxt = y0_r; y1_nxt = y1_r; y2_nxt = y2_r;
    shade_nxt      = shade_r;
    sx_nxt         = sx_r;
    step1_nxt      = step1_r;
    step2_nxt      = step2_r;
    acc1_nxt       = acc1_r;
    acc2_nxt       = acc2_r;
    row_nxt        = row_r;
    left_nxt       = left_r;
    spans_nxt      = spans_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_row_nxt    = out_row_r;
    out_x1_nxt     = out_x1_r;
    out_x2_nxt     = out_x2_r;
    out_shade_nxt  = out_shade_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          x0_nxt = sv0_x; x1_nxt = sv1_x; x2_nxt = sv2_x;
          y0_nxt = sv0_y; y1_nxt = sv1_y; y2_nxt = sv2_y;
          shade_nxt = in_shade;
          spans_nxt = '0;
          if (sv1_y == sv2_y) begin
            part_nxt  = P_BFLAT;
            state_nxt = S_E1_GO;
          end else if (sv0_y == sv1_y) begin
            part_nxt  = P_TFLAT;
            state_nxt = S_E1_GO;
          end else begin
            part_nxt  = P_GBOT;
            state_nxt = S_SX_GO;
          end
        end
      end
      S_SX_GO:   state_nxt = S_SX_WAIT;
      S_SX_WAIT: begin
        if (div_rsp.done) begin
          sx_nxt    = div_rsp.quotient[7:0];
          state_nxt = S_E1_GO;
        end
      end
      S_E1_GO:   state_nxt = S_E1_WAIT;
      S_E1_WAIT: begin
        if (div_rsp.done) begin
          step1_nxt = neg1 ? -quo_s : quo_s;
          state_nxt = S_E2_GO;
        end
      end
      S_E2_GO:   state_nxt = S_E2_WAIT;
      S_E2_WAIT: begin
        if (div_rsp.done) begin
          step2_nxt = neg2 ? -quo_s : quo_s;
          acc1_nxt  = $signed({2'b0, part_xs, FRAC_W'(0)});
          acc2_nxt  = $signed({2'b0, part_xs, FRAC_W'(0)});
          row_nxt   = part_row;
          left_nxt  = part_cnt;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_row_nxt    = row_r;
          out_x1_nxt     = col_of(acc1_r);
          out_x2_nxt     = col_of(acc2_r);
          out_shade_nxt  = shade_r;
          out_last_nxt   = span_last;
          acc1_nxt       = acc1_r + step1_r;
          acc2_nxt       = acc2_r + step2_r;
          row_nxt        = part_up ? row_r + 1'b1 : row_r - 1'b1;
          left_nxt       = left_r - 1'b1;
          spans_nxt      = spans_r + 1'b1;
          if (span_last) begin
            state_nxt = S_IDLE;
          end else if (left_r == CNT_W'(1)) begin
            // lower part done: set up the upper part
            part_nxt  = P_GTOP;
            state_nxt = S_E1_GO;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    part_r      <= part_nxt;
    x0_r        <= x0_nxt;
    x1_r        <= x1_nxt;
    x2_r        <= x2_nxt;
    y0_r        <= y0_nxt;
    y1_r        <= y1_nxt;
    y2_r        <= y2_nxt;
    shade_r     <= shade_nxt;
    sx_r        <= sx_nxt;
    step1_r     <= step1_nxt;
    step2_r     <= step2_nxt;
    acc1_r      <= acc1_nxt;
    acc2_r      <= acc2_nxt;
    row_r       <= row_nxt;
    left_r      <= left_nxt;
    spans_r     <= spans_nxt;
    out_row_r   <= out_row_nxt;
    out_x1_r    <= out_x1_nxt;
    out_x2_r    <= out_x2_nxt;
    out_shade_r <= out_shade_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b0, out_shade_r, out_x2_r, out_x1_r, out_row_r};
  assign out_tlast  = out_last_r;

endmodule

[design/tsg_checker.sv]
// ----------------------------------------------------------------------------
// tsg_checker: port-level checks for the triangle span generator
// Watches the handshakes of both channels and the reset behaviour.
// ----------------------------------------------------------------------------
module tsg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // a stalled span word stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("span word withdrawn while stalled");

  // a stalled span word holds its contents
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("span word changed while stalled");

  // one triangle at a time: busy right after a triangle is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again straight after a triangle");

  // reset leaves the block idle with nothing offered
  assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

endmodule

bind triangle_scanline_span_generator tsg_checker u_tsg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);
